[hdl/tqle_pkg.sv]
// Package of shared constants, transaction types and helpers for the Q-learning engine.
package tqle_pkg;

  // Table geometry.
  localparam int LINKS    = 3;
  localparam int CHANNELS = 4;
  localparam int STATES   = 1 << CHANNELS;
  localparam int ROWS     = LINKS * STATES;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  localparam int Q_W      = 32;
  localparam int ROW_DW   = CHANNELS * Q_W;
  localparam int FRAC     = 16;
  localparam int CFG_DW   = 16;

  // Collaborative reward: floor((total << 8) / LINKS) by reciprocal multiply.
  localparam int RWD_W    = 24;
  localparam int RWD_SH   = RWD_W + $clog2(LINKS);
  localparam logic [RWD_SH:0] RWD_RECIP =
    (RWD_SH + 1)'(((64'd1 << RWD_SH) + 64'(LINKS) - 64'd1) / 64'(LINKS));

  // Tie pick modulo the tie count, by reciprocal multiply.
  localparam int TIE_W    = 16;
  localparam int TIE_SH   = 19;

  typedef logic signed [Q_W-1:0] q_t;
  typedef q_t [CHANNELS-1:0] qrow_t;

  typedef enum logic [1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_DISCOUNT      = 2'd1,
    CFG_REWARD_MODE   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ACT_CHOOSE = 1'b0,
    ACT_UPDATE = 1'b1
  } act_t;

  typedef struct packed {
    logic        action;
    logic [1:0]  link;
    logic [3:0]  state;
    logic [1:0]  channel;
    logic [3:0]  next_state;
    logic [15:0] own_throughput;
    logic [15:0] total_throughput;
    logic [16:0] epsilon;
    logic [15:0] uniform_draw;
    logic [1:0]  random_channel;
    logic [15:0] tie_pick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         chosen_channel;
    logic               explored;
    logic signed [31:0] q_value;
    logic               saturated;
  } out_item_t;

  // Reciprocal of a tie count, ceil(2^TIE_SH / count).
  function automatic logic [TIE_SH:0] tie_recip(input logic [CNT_W-1:0] cnt);
    logic [TIE_SH:0] r;
    case (int'(cnt))
      1:       r = (TIE_SH + 1)'((2 ** TIE_SH) / 1);
      2:       r = (TIE_SH + 1)'((2 ** TIE_SH) / 2);
      3:       r = (TIE_SH + 1)'((2 ** TIE_SH + 2) / 3);
      4:       r = (TIE_SH + 1)'((2 ** TIE_SH) / 4);
      5:       r = (TIE_SH + 1)'((2 ** TIE_SH + 4) / 5);
      6:       r = (TIE_SH + 1)'((2 ** TIE_SH + 5) / 6);
      7:       r = (TIE_SH + 1)'((2 ** TIE_SH + 6) / 7);
      8:       r = (TIE_SH + 1)'((2 ** TIE_SH) / 8);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/tqle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tqle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tabular_q_learning_engine.sv]
// Top level of the tabular Q-learning engine with epsilon-greedy channel choice.
//
//   Channel   Direction  Handshake                 Payload
//   item      in         item_valid / item_ready   in_item_t
//   result    out        result_valid / result_ready  out_item_t
//   cfg       in         cfg_write (no wait)       cfg_index, cfg_data
//
// One transaction is handled at a time. A greedy choose steps through S_C_MAX,
// S_C_CNT, S_C_SEL and S_DONE, an exploring choose through S_C_MAX and S_DONE, an
// update through S_U_NXT to S_U_WR and S_DONE, and a missing link's item straight
// to S_DONE; the single RAM read port and two chained multiplies set these steps.
// Reset clears the row valid bits at once, so the table reads as zero with no
// clearing pass. A stalled result port holds the block in its last step.
module tabular_q_learning_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tqle_pkg::in_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output tqle_pkg::out_item_t  result,
  input  logic                 cfg_write,
  input  tqle_pkg::cfg_idx_t   cfg_index,
  input  logic [tqle_pkg::CFG_DW-1:0] cfg_data
);
  import tqle_pkg::*;

  localparam int GP_W  = Q_W + 17;
  localparam int TD_W  = Q_W + 2;
  localparam int AP_W  = TD_W + 17;
  localparam int NV_W  = Q_W + 4;
  localparam int TP_W  = TIE_W + TIE_SH + 1;
  localparam int REM_W = TIE_W + CNT_W;
  localparam int RP_W  = RWD_W + RWD_SH + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_C_MAX = 10'b00_0000_0010,
    S_C_CNT = 10'b00_0000_0100,
    S_C_SEL = 10'b00_0000_1000,
    S_U_NXT = 10'b00_0001_0000,
    S_U_OLD = 10'b00_0010_0000,
    S_U_TD  = 10'b00_0100_0000,
    S_U_MUL = 10'b00_1000_0000,
    S_U_WR  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } fsm_t;

  fsm_t                    fsm;
  logic [15:0]             learning_rate;
  logic [15:0]             discount;
  logic                    reward_mode;
  in_item_t                job;
  logic [ROW_W-1:0]        row_addr;
  logic [ROWS-1:0]         row_valid;
  logic                    rd_ok;
  qrow_t                   cur_row;
  q_t                      best;
  logic [RWD_W-1:0]        reward;
  logic signed [GP_W-1:0]  gprod;
  logic signed [TD_W-1:0]  td;
  logic signed [AP_W-1:0]  aprod;
  logic [CHANNELS-1:0]     eq_mask;
  logic [CNT_W-1:0]        tie_cnt;
  logic [TIE_W-1:0]        tie_quot;
  out_item_t               res;

  logic [ROW_W-1:0]        raddr;
  logic [ROW_DW-1:0]       rdata;
  logic                    ram_we;
  qrow_t                   row_now;
  qrow_t                   wr_row;
  logic [CH_W-1:0]         job_ch;
  logic [CH_W-1:0]         job_rnd;
  logic                    explore;
  logic [ROW_W-1:0]        item_row_addr;
  logic [ROW_W-1:0]        item_next_addr;
  logic                    link_ok;
  logic [RP_W-1:0]         rwd_prod;
  logic [RWD_W-1:0]        rwd_share;
  logic [CHANNELS-1:0]     eq_now;
  logic [CNT_W-1:0]        cnt_now;
  logic [TP_W-1:0]         tie_prod;
  logic [REM_W-1:0]        tie_rem;
  logic [CNT_W-1:0]        tie_k;
  logic [CNT_W-1:0]        seen;
  logic                    found;
  logic [CH_W-1:0]         pick;
  logic signed [TD_W-1:0]  td_now;
  logic signed [NV_W-1:0]  nv;
  logic                    sat_now;
  q_t                      nv_clamped;
  logic                    out_free;

  // Largest entry of a row.
  function automatic q_t row_max(input qrow_t r);
    q_t m;
    m = r[0];
    for (int c = 1; c < CHANNELS; c++) begin
      if (r[c] > m) begin
        m = r[c];
      end
    end
    return m;
  endfunction

  // Table storage: one row of all channels per word.
  tqle_ram #(
    .WIDTH (ROW_DW),
    .DEPTH (ROWS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_addr),
    .wdata (wr_row),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Decode of the incoming and the held transaction.
  assign item_ready     = (fsm == S_IDLE);
  assign link_ok        = (int'(item.link) < LINKS);
  assign item_row_addr  = ROW_W'({item.link, CHANNELS'(item.state)});
  assign item_next_addr = ROW_W'({item.link, CHANNELS'(item.next_state)});
  assign job_ch         = CH_W'(job.channel % CHANNELS);
  assign job_rnd        = CH_W'(job.random_channel % CHANNELS);
  assign explore        = ({1'b0, job.uniform_draw} < job.epsilon);
  assign row_now        = rd_ok ? qrow_t'(rdata) : '0;
  assign out_free       = !result_valid || result_ready;
  assign ram_we         = (fsm == S_U_WR);

  // An update reads the next row first, then its own row.
  always_comb begin
    if (fsm == S_IDLE) begin
      raddr = (item.action == ACT_UPDATE) ? item_next_addr : item_row_addr;
    end else begin
      raddr = row_addr;
    end
  end

  // Collaborative reward share.
  assign rwd_prod  = RP_W'({job.total_throughput, 8'd0}) * RP_W'(RWD_RECIP);
  assign rwd_share = RWD_W'(rwd_prod >> RWD_SH);

  // Tie detection and count over the held row.
  always_comb begin
    cnt_now = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      eq_now[c] = (cur_row[c] == best);
      cnt_now   = cnt_now + CNT_W'(eq_now[c]);
    end
  end

  assign tie_prod = TP_W'(job.tie_pick) * TP_W'(tie_recip(cnt_now));

  // Remainder of the tie pick, then the matching tied channel in ascending order.
  always_comb begin
    tie_rem = REM_W'(job.tie_pick) - REM_W'(tie_quot) * REM_W'(tie_cnt);
    tie_k   = CNT_W'(tie_rem);
    seen    = '0;
    found   = 1'b0;
    pick    = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (eq_mask[c] && !found) begin
        if (seen == tie_k) begin
          pick  = CH_W'(c);
          found = 1'b1;
        end else begin
          seen = seen + CNT_W'(1);
        end
      end
    end
  end

  // Temporal difference and the new entry with saturation.
  assign td_now = TD_W'($signed({1'b0, reward})) + TD_W'(gprod >>> FRAC)
                - TD_W'(cur_row[job_ch]);
  assign nv     = NV_W'(cur_row[job_ch]) + NV_W'(aprod >>> FRAC);
  assign sat_now = !((&nv[NV_W-1:Q_W-1]) || !(|nv[NV_W-1:Q_W-1]));

  always_comb begin
    if (!sat_now) begin
      nv_clamped = Q_W'(nv);
    end else if (nv[NV_W-1]) begin
      nv_clamped = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      nv_clamped = {1'b0, {(Q_W-1){1'b1}}};
    end
    wr_row         = cur_row;
    wr_row[job_ch] = nv_clamped;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= 16'd6554;
      discount      <= 16'd32768;
      reward_mode   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEARNING_RATE: learning_rate <= cfg_data[15:0];
        CFG_DISCOUNT:      discount      <= cfg_data[15:0];
        CFG_REWARD_MODE:   reward_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Row valid bits: a row never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[row_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= row_valid[raddr];
  end

  // Sequencer for choose and update transactions.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
    end else begin
      unique case (fsm)
        S_IDLE: begin
          if (item_valid) begin
            if (!link_ok) begin
              fsm <= S_DONE;
            end else if (item.action == ACT_UPDATE) begin
              fsm <= S_U_NXT;
            end else begin
              fsm <= S_C_MAX;
            end
          end
        end
        S_C_MAX: fsm <= explore ? S_DONE : S_C_CNT;
        S_C_CNT: fsm <= S_C_SEL;
        S_C_SEL: fsm <= S_DONE;
        S_U_NXT: fsm <= S_U_OLD;
        S_U_OLD: fsm <= S_U_TD;
        S_U_TD:  fsm <= S_U_MUL;
        S_U_MUL: fsm <= S_U_WR;
        S_U_WR:  fsm <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            fsm <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (fsm)
      S_IDLE: begin
        job      <= item;
        row_addr <= item_row_addr;
        res      <= '0;
      end
      S_C_MAX: begin
        cur_row <= row_now;
        best    <= row_max(row_now);
        res.chosen_channel <= 2'(job_rnd);
        res.explored       <= 1'b1;
        res.q_value        <= row_now[job_rnd];
        res.saturated      <= 1'b0;
      end
      S_C_CNT: begin
        eq_mask  <= eq_now;
        tie_cnt  <= cnt_now;
        tie_quot <= tie_prod[TIE_SH +: TIE_W];
      end
      S_C_SEL: begin
        res.chosen_channel <= 2'(pick);
        res.explored       <= 1'b0;
        res.q_value        <= cur_row[pick];
        res.saturated      <= 1'b0;
      end
      S_U_NXT: begin
        best   <= row_max(row_now);
        reward <= reward_mode ? rwd_share : {job.own_throughput, 8'd0};
      end
      S_U_OLD: begin
        cur_row <= row_now;
        gprod   <= best * $signed({1'b0, discount});
      end
      S_U_TD: begin
        td <= td_now;
      end
      S_U_MUL: begin
        aprod <= td * $signed({1'b0, learning_rate});
      end
      S_U_WR: begin
        res.chosen_channel <= 2'(job_ch);
        res.explored       <= 1'b0;
        res.q_value        <= nv_clamped;
        res.saturated      <= sat_now;
      end
      default: ;
    endcase
  end

  // Output register toward the result port.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fsm == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fsm == S_DONE && out_free) begin
      result <= res;
    end
  end

endmodule
